// ===== rtl/hvt_pkg.sv =====
package hvt_pkg;

  localparam int CoefW  = 16;   // signed Q4.12 matrix entry
  localparam int CoordW = 32;   // signed Q16.16 coordinate
  localparam int ProdW  = CoefW + CoordW;
  localparam int SumW   = ProdW + 2;
  localparam int FracDrop = 12;
  localparam int RndW   = SumW - FracDrop;
  localparam int CfgDataW = 64;
  localparam int CfgAddrW = 5;

  localparam logic signed [CoordW-1:0] OneQ16 = 32'sh0001_0000;
  localparam logic signed [SumW-1:0]   RoundHalf = 50'sd2048;

  typedef enum logic [2:0] {
    KIND_HOMOG = 3'd0,
    KIND_POS3  = 3'd1,
    KIND_VEC3  = 3'd2,
    KIND_POS2  = 3'd3,
    KIND_VEC2  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_COL_I = 2'd0,
    REG_COL_J = 2'd1,
    REG_COL_K = 2'd2,
    REG_COL_T = 2'd3
  } reg_idx_t;

  localparam logic [CfgDataW-1:0] ColIReset = 64'h0000_0000_0000_1000;
  localparam logic [CfgDataW-1:0] ColJReset = 64'h0000_0000_1000_0000;
  localparam logic [CfgDataW-1:0] ColKReset = 64'h0000_1000_0000_0000;
  localparam logic [CfgDataW-1:0] ColTReset = 64'h1000_0000_0000_0000;

  // x,y,z,w from index 0 up
  typedef logic [3:0][CoordW-1:0] vec4_t;
  // entries of i,j,k,t columns for one result component
  typedef logic [3:0][CoefW-1:0] row4_t;
  typedef logic [3:0][CfgDataW-1:0] cols_t;

  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
  } lane_ctl_t;

endpackage

// ===== rtl/homogeneous_vertex_transform.sv =====
// Transforms one vertex per beat by a 4x4 column matrix: each output component
// is I*x + J*y + K*z + T*w with Q4.12 matrix entries and Q16.16 coordinates,
// rounded half up to Q16.16 and clamped to 32 bits (out_tuser flags a clamp).
// in_tuser selects the kind: homogeneous, 3D position (w = 1), 3D vector
// (w = 0), 2D position or 2D vector (z = 0 as well); codes 5 to 7 act as
// homogeneous. The datapath is four register stages (input/kind select,
// sixteen 16x32 multipliers, sum and round, clamp into the output register),
// and one vertex can enter every cycle unless out_tready holds it back.
// A stage stalls only when the stage after it is full and cannot move, so
// beats are taken while a result waits on out_tready until all stages fill.
// Matrix columns are 64-bit registers at cfg byte addresses 0, 8, 16 and 24
// (I, J, K, T; entry x in bits 15:0 up to w in 63:48); write them only while
// no vertex is in flight.
module homogeneous_vertex_transform (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [127:0]                  in_tdata,   // in_x, in_y, in_z, in_w
  input  logic [2:0]                    in_tuser,   // kind

  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [127:0]                  out_tdata,  // out_x, out_y, out_z, out_w
  output logic [0:0]                    out_tuser,  // saturated

  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [hvt_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [hvt_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [hvt_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  hvt_pkg::cols_t     cols;
  hvt_pkg::vec4_t     vec_nxt;
  hvt_pkg::vec4_t     vec_r;
  hvt_pkg::kind_t     kind;
  hvt_pkg::lane_ctl_t ctl;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic [3:0] lane_sat;

  assign cfg_pready = 1'b1;

  hvt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cols    (cols)
  );

  // a stage moves when it is empty or the next one moves
  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign ctl.ld2 = rdy2 && v1_r;
  assign ctl.ld3 = rdy3 && v2_r;
  assign ctl.ld4 = rdy4 && v3_r;

  // stage 1: kind selects forced z and w
  assign kind = hvt_pkg::kind_t'(in_tuser);

  always_comb begin
    vec_nxt = in_tdata;
    case (kind)
      hvt_pkg::KIND_POS3: vec_nxt[3] = hvt_pkg::OneQ16;
      hvt_pkg::KIND_VEC3: vec_nxt[3] = '0;
      hvt_pkg::KIND_POS2: begin
        vec_nxt[2] = '0;
        vec_nxt[3] = hvt_pkg::OneQ16;
      end
      hvt_pkg::KIND_VEC2: begin
        vec_nxt[2] = '0;
        vec_nxt[3] = '0;
      end
      default: vec_nxt = in_tdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      vec_r <= vec_nxt;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    hvt_pkg::row4_t row;
    logic signed [hvt_pkg::CoordW-1:0] res;

    for (genvar n = 0; n < 4; n++) begin : g_row
      assign row[n] = cols[n][c*hvt_pkg::CoefW +: hvt_pkg::CoefW];
    end

    hvt_lane u_lane (
      .clk (clk),
      .ctl (ctl),
      .row (row),
      .vec (vec_r),
      .res (res),
      .sat (lane_sat[c])
    );

    assign out_tdata[c*hvt_pkg::CoordW +: hvt_pkg::CoordW] = res;
  end

  assign out_tvalid   = v4_r;
  assign out_tuser[0] = |lane_sat;

endmodule

// ===== rtl/hvt_cfg.sv =====
module hvt_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hvt_pkg::CfgAddrW-1:0]  paddr,
  input  logic [hvt_pkg::CfgDataW-1:0]  pwdata,
  output logic [hvt_pkg::CfgDataW-1:0]  prdata,
  output hvt_pkg::cols_t                cols
);

  hvt_pkg::cols_t    cols_r;
  hvt_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx   = hvt_pkg::reg_idx_t'(paddr[4:3]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r[hvt_pkg::REG_COL_I] <= hvt_pkg::ColIReset;
      cols_r[hvt_pkg::REG_COL_J] <= hvt_pkg::ColJReset;
      cols_r[hvt_pkg::REG_COL_K] <= hvt_pkg::ColKReset;
      cols_r[hvt_pkg::REG_COL_T] <= hvt_pkg::ColTReset;
    end else if (wr_en) begin
      cols_r[idx] <= pwdata;
    end
  end

  always_comb begin
    case (idx)
      hvt_pkg::REG_COL_I: prdata = cols_r[hvt_pkg::REG_COL_I];
      hvt_pkg::REG_COL_J: prdata = cols_r[hvt_pkg::REG_COL_J];
      hvt_pkg::REG_COL_K: prdata = cols_r[hvt_pkg::REG_COL_K];
      hvt_pkg::REG_COL_T: prdata = cols_r[hvt_pkg::REG_COL_T];
      default:            prdata = '0;
    endcase
  end

  assign cols = cols_r;

endmodule

// ===== rtl/hvt_lane.sv =====
module hvt_lane (
  input  logic                              clk,
  input  hvt_pkg::lane_ctl_t                ctl,
  input  hvt_pkg::row4_t                    row,
  input  hvt_pkg::vec4_t                    vec,
  output logic signed [hvt_pkg::CoordW-1:0] res,
  output logic                              sat
);

  logic signed [hvt_pkg::ProdW-1:0]  prod_nxt [4];
  logic signed [hvt_pkg::ProdW-1:0]  prod_r   [4];
  logic signed [hvt_pkg::SumW-1:0]   sum_nxt;
  logic signed [hvt_pkg::RndW-1:0]   rnd_r;
  logic signed [hvt_pkg::CoordW-1:0] res_nxt;
  logic signed [hvt_pkg::CoordW-1:0] res_r;
  logic                              sat_nxt;
  logic                              sat_r;
  logic                              fits;

  // stage 2: one product per matrix column
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      prod_nxt[n] = $signed(row[n]) * $signed(vec[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      for (int n = 0; n < 4; n++) begin
        prod_r[n] <= prod_nxt[n];
      end
    end
  end

  // stage 3: exact sum, round half up by floor shift
  assign sum_nxt = hvt_pkg::SumW'(prod_r[0]) + hvt_pkg::SumW'(prod_r[1])
                 + hvt_pkg::SumW'(prod_r[2]) + hvt_pkg::SumW'(prod_r[3])
                 + hvt_pkg::RoundHalf;

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      rnd_r <= sum_nxt[hvt_pkg::SumW-1:hvt_pkg::FracDrop];
    end
  end

  // stage 4: clamp to 32 bits
  assign fits = (rnd_r[hvt_pkg::RndW-1:hvt_pkg::CoordW-1] == '0) ||
                (rnd_r[hvt_pkg::RndW-1:hvt_pkg::CoordW-1] == '1);

  always_comb begin
    if (fits) begin
      res_nxt = rnd_r[hvt_pkg::CoordW-1:0];
      sat_nxt = 1'b0;
    end else if (rnd_r[hvt_pkg::RndW-1]) begin
      res_nxt = {1'b1, {(hvt_pkg::CoordW-1){1'b0}}};
      sat_nxt = 1'b1;
    end else begin
      res_nxt = {1'b0, {(hvt_pkg::CoordW-1){1'b1}}};
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld4) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

// ===== tb/vertex_check_pkg.sv =====
package vertex_check_pkg;
  import hvt_pkg::*;

  localparam longint CompMax = 64'sd2147483647;
  localparam longint CompMin = -64'sd2147483648;

  typedef struct {
    logic [3:0][CoordW-1:0] comp;
    logic                   sat;
  } vertex_out_t;

  class vertex_ledger;
    cols_t         cols;
    vertex_out_t   expected_vertices[$];
    int unsigned   errors;
    string         comp_name[4] = '{"out_x", "out_y", "out_z", "out_w"};

    function new();
      cols[REG_COL_I] = ColIReset;
      cols[REG_COL_J] = ColJReset;
      cols[REG_COL_K] = ColKReset;
      cols[REG_COL_T] = ColTReset;
      errors = 0;
    endfunction

    function void set_col(reg_idx_t idx, logic [CfgDataW-1:0] val);
      cols[idx] = val;
    endfunction

    function int unsigned pending();
      return expected_vertices.size();
    endfunction

    // transform one accepted vertex beat and queue the expected result
    function void note_vertex(logic [127:0] data, logic [2:0] code);
      longint      crd[4];
      longint      acc;
      vertex_out_t e;
      for (int n = 0; n < 4; n++) crd[n] = longint'($signed(data[32*n +: 32]));
      case (code)
        KIND_POS3: crd[3] = OneQ16;
        KIND_VEC3: crd[3] = 0;
        KIND_POS2: begin
          crd[2] = 0;
          crd[3] = OneQ16;
        end
        KIND_VEC2: begin
          crd[2] = 0;
          crd[3] = 0;
        end
        default: ;  // homogeneous, unused codes land here too
      endcase
      e.sat = 1'b0;
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int r = 0; r < 4; r++)
          acc += longint'($signed(cols[r][16*c +: 16])) * crd[r];
        // round half up: floor shift after adding half an lsb
        acc = (acc + RoundHalf) >>> FracDrop;
        if (acc > CompMax) begin
          acc = CompMax;
          e.sat = 1'b1;
        end else if (acc < CompMin) begin
          acc = CompMin;
          e.sat = 1'b1;
        end
        e.comp[c] = acc[31:0];
      end
      expected_vertices.push_back(e);
    endfunction

    function void check_vertex(logic [127:0] data, logic sat);
      vertex_out_t e;
      if (expected_vertices.size() == 0) begin
        $error("result beat with no vertex outstanding: tdata %h", data);
        errors++;
        return;
      end
      e = expected_vertices.pop_front();
      for (int c = 0; c < 4; c++) begin
        if (data[32*c +: 32] !== e.comp[c]) begin
          $error("%s expected %0d got %0d", comp_name[c], $signed(e.comp[c]),
                 $signed(data[32*c +: 32]));
          errors++;
        end
      end
      if (sat !== e.sat) begin
        $error("saturated expected %0b got %0b", e.sat, sat);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/homogeneous_vertex_transform_test.sv =====
module homogeneous_vertex_transform_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hvt_pkg::*;
  import vertex_check_pkg::*;

  localparam logic [2:0] KIND_LAST_CODE = 3'd7;

  typedef enum {
    READY_ALWAYS,
    READY_HALF,
    READY_MOSTLY,
    READY_PERIODIC,
    READY_BURSTY
  } ready_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [127:0]         in_tdata;   // in_x, in_y, in_z, in_w
  logic [2:0]           in_tuser;   // kind
  logic                 out_tvalid;
  logic                 out_tready;
  logic [127:0]         out_tdata;  // out_x, out_y, out_z, out_w
  logic [0:0]           out_tuser;  // saturated
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [CfgAddrW-1:0]  cfg_paddr;
  logic [CfgDataW-1:0]  cfg_pwdata;
  logic [CfgDataW-1:0]  cfg_prdata;
  logic                 cfg_pready;

  vertex_ledger ledger = new();

  int unsigned burst_left;
  bit          steady;
  ready_mode_t ready_mode;
  int unsigned mode_left;
  int unsigned ready_ctr;

  homogeneous_vertex_transform dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // receiver backpressure, with a pattern that switches at random
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 4));
      mode_left = $urandom_range(64, 256);
    end
    mode_left--;
    ready_ctr++;
    case (ready_mode)
      READY_ALWAYS:   out_tready = 1'b1;
      READY_HALF:     out_tready = 1'($urandom_range(0, 1));
      READY_MOSTLY:   out_tready = ($urandom_range(0, 7) != 0);
      READY_PERIODIC: out_tready = (ready_ctr % 4 != 0);
      default:        out_tready = (ready_ctr % 24 >= 8);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) ledger.note_vertex(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready) ledger.check_vertex(out_tdata, out_tuser[0]);
  end

  task automatic cfg_write(reg_idx_t idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 3'b000};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    ledger.set_col(idx, val);
  endtask

  task automatic cfg_read(reg_idx_t idx);
    logic [CfgDataW-1:0] got;
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = {idx, 3'b000};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    if (got !== ledger.cols[idx]) begin
      $error("%s readback expected %h got %h", idx.name(), ledger.cols[idx], got);
      ledger.errors++;
    end
  endtask

  task automatic check_matrix();
    cfg_read(REG_COL_I);
    cfg_read(REG_COL_J);
    cfg_read(REG_COL_K);
    cfg_read(REG_COL_T);
  endtask

  task automatic load_matrix(cols_t m);
    cfg_write(REG_COL_I, m[REG_COL_I]);
    cfg_write(REG_COL_J, m[REG_COL_J]);
    cfg_write(REG_COL_K, m[REG_COL_K]);
    cfg_write(REG_COL_T, m[REG_COL_T]);
    check_matrix();
  endtask

  // bursts of random length with random gaps, unless in a steady stretch
  task automatic pace();
    int unsigned gap;
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 20);
    gap = $urandom_range(1, 8);
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] w, logic [2:0] code);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {w, z, y, x};
    in_tuser = code;
    do @(posedge clk); while (!in_tready);
    pace();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: ;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = '0;
          default: v = OneQ16;
        endcase
      end
      default: v = v >>> $urandom_range(4, 26);
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_coef();
    logic signed [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 4))
      0: ;
      1: begin
        case ($urandom_range(0, 4))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = '0;
          3: v = 16'h1000;
          default: v = 16'hF000;
        endcase
      end
      default: v = v >>> $urandom_range(2, 15);
    endcase
    return v;
  endfunction

  task automatic stream_vertices(int unsigned count);
    steady = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < count; i++) begin
      // hold the sender off once per phase until every result is back
      if (i == count / 2) wait_drained();
      send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  3'($urandom_range(0, KIND_LAST_CODE)));
    end
    wait_drained();
  endtask

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    cols_t m;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // identity matrix out of reset
    check_matrix();
    steady = 1'b0;
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, KIND_HOMOG);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, KIND_HOMOG);
    send_vertex('0, '0, '0, '0, KIND_HOMOG);
    // forced z and w per kind, spare codes act as homogeneous
    for (int k = KIND_POS3; k <= KIND_LAST_CODE; k++)
      send_vertex(32'h1234_5678, 32'hEDCB_A988, 32'h00AB_CDEF, 32'hFEDC_BA98, 3'(k));
    wait_drained();

    // one lsb coefficients expose the half-up rounding ties
    m = '0;
    m[REG_COL_I] = {16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001};
    load_matrix(m);
    send_vertex(32'd2048, rand_coord(), rand_coord(), rand_coord(), KIND_VEC2);
    send_vertex(-32'sd2048, rand_coord(), rand_coord(), rand_coord(), KIND_VEC2);
    send_vertex(32'd2047, rand_coord(), rand_coord(), rand_coord(), KIND_VEC2);
    send_vertex(-32'sd2049, rand_coord(), rand_coord(), rand_coord(), KIND_VEC2);
    send_vertex(32'd6144, rand_coord(), rand_coord(), rand_coord(), KIND_VEC2);
    send_vertex(-32'sd6144, rand_coord(), rand_coord(), rand_coord(), KIND_VEC2);
    wait_drained();

    m = {4{64'h7FFF_7FFF_7FFF_7FFF}};
    load_matrix(m);
    stream_vertices(100);
    m = {4{64'h8000_8000_8000_8000}};
    load_matrix(m);
    stream_vertices(100);
    m = '0;
    load_matrix(m);
    stream_vertices(60);

    for (int p = 0; p < 9; p++) begin
      for (int r = 0; r < 4; r++) m[r] = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
      load_matrix(m);
      stream_vertices(150);
    end

    m[REG_COL_I] = ColIReset;
    m[REG_COL_J] = ColJReset;
    m[REG_COL_K] = ColKReset;
    m[REG_COL_T] = ColTReset;
    load_matrix(m);
    stream_vertices(80);

    if (ledger.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
